>>> hdl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and character constants for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Token kinds as seen on the output port
  typedef enum logic [3:0] {
    KIND_SEMI     = 4'd0,
    KIND_EQUALS   = 4'd1,
    KIND_OPEN     = 4'd2,
    KIND_CLOSE    = 4'd3,
    KIND_OPERATOR = 4'd4,
    KIND_NUMBER   = 4'd5,
    KIND_IDENT    = 4'd6,
    KIND_KEYWORD  = 4'd7,
    KIND_ILLEGAL  = 4'd8
  } kind_e;

  // Character codes the scanner reacts to
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  // Token queue between front and back end
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_CNT_BITS = 3;

  // One finished token with output-width fields
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] start_col;
    logic [15:0] end_col;
    logic [15:0] len;
  } tok_t;

  // All tokens caused by one source byte (one or two)
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic pair;
  } bundle_t;

  // Keyword text, one character per match position
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h56;  // V
      2'd1:    ch = 8'h61;  // a
      2'd2:    ch = 8'h72;  // r
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: tracks line, column and the pending run, classifies each
// source byte and pushes the tokens it causes as one bundle.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_byte_i,
  input  logic            start_of_source_i,
  input  logic            end_of_source_i,
  input  logic            full_i,
  output logic            push_o,
  output stt_pkg::bundle_t bundle_o
);
  import stt_pkg::*;

  localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] ColMax  = {COLUMN_BITS{1'b1}};
  localparam int unsigned LineW = (LINE_BITS > 16) ? LINE_BITS : 16;
  localparam int unsigned ColW  = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_NUMBER = 3'b010,
    MODE_IDENT  = 3'b100
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [COLUMN_BITS-1:0] start_q, start_d;
  logic [COLUMN_BITS-1:0] len_q, len_d;
  logic [1:0]             kwp_q, kwp_d;
  logic                   kwm_q, kwm_d;
  logic                   halted_q, halted_d;

  mode_e                  cur_mode, mode_p;
  logic [LINE_BITS-1:0]   cur_line, line_p;
  logic [COLUMN_BITS-1:0] cur_col, col_p, cur_len, len_p, start_p;
  logic [1:0]             cur_kwp, kwp_p;
  logic                   cur_kwm, kwm_p, cur_halted, halted_p;
  logic                   accept;
  logic                   is_digit, is_alpha, run_grows, kw_hit;
  logic                   a_fire, b_fire, c_fire;
  kind_e                  b_kind;
  tok_t                   tok_a, tok_b, tok_c;

  // Clamp counters to the 16-bit output fields
  function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
    logic [LineW-1:0] w;
    w = LineW'(v);
    return (w > LineW'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] sat_col(input logic [COLUMN_BITS-1:0] v);
    logic [ColW-1:0] w;
    w = ColW'(v);
    return (w > ColW'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
    return (v == ColMax) ? v : v + 1'b1;
  endfunction

  // Build the token of a finished number or identifier run
  function automatic tok_t run_tok(input mode_e m, input logic [COLUMN_BITS-1:0] s,
                                   input logic [COLUMN_BITS-1:0] l, input logic [1:0] kp,
                                   input logic km, input logic [LINE_BITS-1:0] ln);
    tok_t t;
    logic [COLUMN_BITS:0]   sum;
    logic [COLUMN_BITS-1:0] e;
    sum = {1'b0, s} + {1'b0, l} - {{COLUMN_BITS{1'b0}}, 1'b1};
    e   = sum[COLUMN_BITS] ? ColMax : sum[COLUMN_BITS-1:0];
    if (m == MODE_IDENT) begin
      t.kind = (km && kp == 2'd3) ? KIND_KEYWORD : KIND_IDENT;
    end else begin
      t.kind = KIND_NUMBER;
    end
    t.ch        = 8'h00;
    t.line      = sat_line(ln);
    t.start_col = sat_col(s);
    t.end_col   = sat_col(e);
    t.len       = sat_col(l);
    return t;
  endfunction

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  // Apply start of source before the byte is scanned
  always_comb begin
    if (start_of_source_i) begin
      cur_mode   = MODE_IDLE;
      cur_line   = LINE_BITS'(1);
      cur_col    = '0;
      cur_len    = '0;
      cur_kwp    = 2'd0;
      cur_kwm    = 1'b0;
      cur_halted = 1'b0;
    end else begin
      cur_mode   = mode_q;
      cur_line   = line_q;
      cur_col    = col_q;
      cur_len    = len_q;
      cur_kwp    = kwp_q;
      cur_kwm    = kwm_q;
      cur_halted = halted_q;
    end
  end

  assign is_digit  = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
  assign is_alpha  = ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A)) ||
                     ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A));
  assign run_grows = ((cur_mode == MODE_NUMBER) && is_digit) ||
                     ((cur_mode == MODE_IDENT) &&
                      (is_alpha || is_digit || char_byte_i == CHAR_UNDER));
  assign kw_hit    = cur_kwm && (cur_kwp != 2'd3) && (char_byte_i == kw_char(cur_kwp));

  // Scan the byte: extend, end or start a run, or emit a single-character token
  always_comb begin
    mode_p   = cur_mode;
    line_p   = cur_line;
    col_p    = cur_col;
    start_p  = start_q;
    len_p    = cur_len;
    kwp_p    = cur_kwp;
    kwm_p    = cur_kwm;
    halted_p = cur_halted;
    a_fire   = 1'b0;
    b_fire   = 1'b0;
    b_kind   = KIND_SEMI;
    if (!cur_halted) begin
      if (run_grows) begin
        col_p = inc_col(cur_col);
        len_p = inc_col(cur_len);
        if (cur_mode == MODE_IDENT) begin
          kwp_p = kw_hit ? cur_kwp + 2'd1 : cur_kwp;
          kwm_p = kw_hit;
        end
      end else begin
        a_fire = (cur_mode != MODE_IDLE);
        mode_p = MODE_IDLE;
        if (char_byte_i == CHAR_NL) begin
          line_p = (cur_line == LineMax) ? cur_line : cur_line + 1'b1;
          col_p  = '0;
        end else begin
          col_p = inc_col(cur_col);
          case (char_byte_i) inside
            CHAR_SEMI: begin
              b_fire = 1'b1;
              b_kind = KIND_SEMI;
            end
            CHAR_EQ: begin
              b_fire = 1'b1;
              b_kind = KIND_EQUALS;
            end
            CHAR_OPEN: begin
              b_fire = 1'b1;
              b_kind = KIND_OPEN;
            end
            CHAR_CLOSE: begin
              b_fire = 1'b1;
              b_kind = KIND_CLOSE;
            end
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: begin
              b_fire = 1'b1;
              b_kind = KIND_OPERATOR;
            end
            CHAR_SPACE, CHAR_TAB, CHAR_UNDER: begin
            end
            default: begin
              if (is_digit) begin
                mode_p  = MODE_NUMBER;
                start_p = inc_col(cur_col);
                len_p   = COLUMN_BITS'(1);
                kwp_p   = 2'd0;
                kwm_p   = 1'b0;
              end else if (is_alpha) begin
                mode_p  = MODE_IDENT;
                start_p = inc_col(cur_col);
                len_p   = COLUMN_BITS'(1);
                kwp_p   = (char_byte_i == kw_char(2'd0)) ? 2'd1 : 2'd0;
                kwm_p   = (char_byte_i == kw_char(2'd0));
              end else begin
                b_fire   = 1'b1;
                b_kind   = KIND_ILLEGAL;
                halted_p = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  // Flush the run left pending at end of source
  assign c_fire = end_of_source_i && !halted_p && (mode_p != MODE_IDLE);

  always_comb begin
    mode_d   = mode_p;
    line_d   = line_p;
    col_d    = col_p;
    start_d  = start_p;
    len_d    = len_p;
    kwp_d    = kwp_p;
    kwm_d    = kwm_p;
    halted_d = halted_p;
    if (c_fire) begin
      mode_d = MODE_IDLE;
      len_d  = '0;
      kwp_d  = 2'd0;
      kwm_d  = 1'b0;
    end
  end

  // Assemble the tokens in the order they occur
  always_comb begin
    tok_a = run_tok(cur_mode, start_q, cur_len, cur_kwp, cur_kwm, cur_line);
    tok_c = run_tok(mode_p, start_p, len_p, kwp_p, kwm_p, line_p);
    tok_b.kind      = b_kind;
    tok_b.ch        = char_byte_i;
    tok_b.line      = sat_line(line_p);
    tok_b.start_col = sat_col(col_p);
    tok_b.end_col   = sat_col(col_p);
    tok_b.len       = 16'd1;
    bundle_o.tok0 = a_fire ? tok_a : (b_fire ? tok_b : tok_c);
    bundle_o.tok1 = (a_fire && b_fire) ? tok_b : tok_c;
    bundle_o.pair = (a_fire && (b_fire || c_fire)) || (b_fire && c_fire);
    push_o        = accept && (a_fire || b_fire || c_fire);
  end

  // Hold scanner state, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= LINE_BITS'(1);
      col_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      kwp_q    <= 2'd0;
      kwm_q    <= 1'b0;
      halted_q <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      col_q    <= col_d;
      start_q  <= start_d;
      len_q    <= len_d;
      kwp_q    <= kwp_d;
      kwm_q    <= kwm_d;
      halted_q <= halted_d;
    end
  end

endmodule

>>> hdl/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue
// Small FIFO of token bundles that decouples the scanner from the output.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t bundle_i,
  input  logic             pop_i,
  output stt_pkg::bundle_t head_o,
  output logic             empty_o,
  output logic             full_o
);
  import stt_pkg::*;

  bundle_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_BITS-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  // Write the incoming bundle
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back
// Output stage: unpacks each bundle into single tokens and holds them in an
// output register until the consumer takes them.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [3:0]       token_kind_o,
  output logic [7:0]       token_char_o,
  output logic [15:0]      line_number_o,
  output logic [15:0]      start_column_o,
  output logic [15:0]      end_column_o,
  output logic [15:0]      token_length_o,
  output logic             last_result_o
);
  import stt_pkg::*;

  logic out_valid_q, sub_q, last_q, load, last_d;
  tok_t tok_q;

  assign load   = !out_valid_q || !out_stall_i;
  assign last_d = sub_q || !head_i.pair;
  assign pop_o  = load && !empty_i && last_d;

  // Track the output register and which half of the bundle is next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        sub_q <= !last_d;
      end
    end
  end

  // Load the next token
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      tok_q  <= sub_q ? head_i.tok1 : head_i.tok0;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = tok_q.kind;
  assign token_char_o   = tok_q.ch;
  assign line_number_o  = tok_q.line;
  assign start_column_o = tok_q.start_col;
  assign end_column_o   = tok_q.end_col;
  assign token_length_o = tok_q.len;
  assign last_result_o  = last_q;

endmodule

>>> hdl/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// Path: the tokens of a taken byte are written into the bundle queue, then loaded into the output register.
// Throughput: one source byte per cycle while the input is not stalled; the output drains one
// token per cycle while not stalled, so a byte that ends a run and gives a token of its own yields two.
// A four-entry bundle queue absorbs such bursts; the input stalls only when it is full.
// Reset: asynchronous, active low; line 1, column 0, no pending run, queue and output empty.
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexical tokenizer: one source byte in, tokens with kind, line,
// start column, end column and length out.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        start_of_source_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  token_char_o,
  output logic [15:0] line_number_o,
  output logic [15:0] start_column_o,
  output logic [15:0] end_column_o,
  output logic [15:0] token_length_o,
  output logic        last_result_o
);
  import stt_pkg::*;

  logic    push, pop, empty, full;
  bundle_t push_bundle, head_bundle;

  // Scan and classify bytes
  stt_front #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_byte_i      (char_byte_i),
    .start_of_source_i(start_of_source_i),
    .end_of_source_i  (end_of_source_i),
    .full_i           (full),
    .push_o           (push),
    .bundle_o         (push_bundle)
  );

  // Buffer token bundles
  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .bundle_i(push_bundle),
    .pop_i   (pop),
    .head_o  (head_bundle),
    .empty_o (empty),
    .full_o  (full)
  );

  // Deliver tokens one at a time
  stt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_bundle),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_char_o  (token_char_o),
    .line_number_o (line_number_o),
    .start_column_o(start_column_o),
    .end_column_o  (end_column_o),
    .token_length_o(token_length_o),
    .last_result_o (last_result_o)
  );

endmodule

>>> hdl/stt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer's output stream.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_byte_i,
  input logic        start_of_source_i,
  input logic        end_of_source_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [7:0]  token_char_o,
  input logic [15:0] line_number_o,
  input logic [15:0] start_column_o,
  input logic [15:0] end_column_o,
  input logic [15:0] token_length_o,
  input logic        last_result_o
);
  import stt_pkg::*;

  // A stalled request is held by the sender
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable({char_byte_i, start_of_source_i, end_of_source_i}))
    else $error("stalled request changed");

  // A stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable({token_kind_o, token_char_o, line_number_o, start_column_o,
                              end_column_o, token_length_o, last_result_o}))
    else $error("stalled result withdrawn");

  // Single-character tokens span one column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_SEMI || token_kind_o == KIND_EQUALS ||
                    token_kind_o == KIND_OPEN || token_kind_o == KIND_CLOSE ||
                    token_kind_o == KIND_OPERATOR || token_kind_o == KIND_ILLEGAL)
    |-> token_length_o == 16'd1 && start_column_o == end_column_o)
    else $error("single-character token with bad span");

  // Runs carry no character and never end before they start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_NUMBER || token_kind_o == KIND_IDENT ||
                    token_kind_o == KIND_KEYWORD)
    |-> token_char_o == 8'h00 && end_column_o >= start_column_o)
    else $error("malformed run token");

  // An illegal byte halts scanning, so nothing follows it for that byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_ILLEGAL |-> last_result_o)
    else $error("illegal result not last");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);
